// ===== sv/olog_pkg.sv =====
// ============================================================================
// olog_pkg
// Shared widths, action codes and defaults for the overwriting ring log.
// ============================================================================
`default_nettype none

package olog_pkg;

   // Field widths of the request, response and register
   localparam int ACTION_W = 2;
   localparam int VALUE_W  = 64;
   localparam int COUNT_W  = 8;
   localparam int CAP_W    = 7;

   // Defaults for the top-level parameters
   localparam int DEPTH_DEFAULT      = 64;
   localparam int ENTRY_BITS_DEFAULT = 64;

   // Capacity after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // Action codes; the fourth code is unused and ignored
   localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_LIST   = 2'd2;

endpackage

`default_nettype wire

// ===== sv/olog_if.sv =====
// ============================================================================
// olog_if
// Valid/ready channels for request items and response items of the ring log.
// ============================================================================
`default_nettype none

interface olog_req_if;
   import olog_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [VALUE_W-1:0]  entry_value;
   logic [COUNT_W-1:0]  remove_count;

   modport source (output valid, output action, output entry_value,
                   output remove_count, input ready);
   modport sink   (input valid, input action, input entry_value,
                   input remove_count, output ready);
endinterface

interface olog_rsp_if;
   import olog_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] listed_value;
   logic               last_of_run;

   modport source (output valid, output listed_value, output last_of_run,
                   input ready);
   modport sink   (input valid, input listed_value, input last_of_run,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/olog_ram.sv =====
// ============================================================================
// olog_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
`default_nettype none

module olog_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write on enable; read data holds until the next read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== sv/overwriting_ring_log_top.sv =====
// ============================================================================
// overwriting_ring_log_top
// Ring log keeping the newest entries up to a programmable capacity.
// ============================================================================
//
// Usage:
//   req_ch carries one item per handshake: append (stores entry_value,
//   dropping the oldest entries when the log is at capacity), remove (drops
//   up to remove_count oldest entries) or list (streams every held entry).
//   rsp_ch carries listed entries, oldest first, last_of_run on the newest.
//   Append and remove leave the block idle, so a new item may follow at once.
//   A list keeps the block busy until every held entry has been read: the
//   entry RAM has one read port with registered read data, and each entry is read once.
//   An accepted list is first registered into the list state; the first entry
//   is then read into the RAM read register, which drives rsp_ch; further entries
//   follow one per cycle while rsp_ch.ready stays high.
//   A list on an empty log produces nothing and leaves the block idle.
//   When the receiver stalls, the RAM read register holds the entry on the
//   response and no further read is issued until it is taken.
//   Reset empties the log and sets capacity to 64; the RAM is not cleared,
//   as only written entries are ever read. csr_write_data sets capacity
//   (0 acts as 1, values above DEPTH act as DEPTH); write only when idle.
//
// ============================================================================
`default_nettype none

module overwriting_ring_log_top #(
   parameter int DEPTH      = olog_pkg::DEPTH_DEFAULT,
   parameter int ENTRY_BITS = olog_pkg::ENTRY_BITS_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   olog_req_if.sink                        req_ch,
   olog_rsp_if.source                      rsp_ch,
   input  wire logic                       csr_write_en,
   input  wire logic [olog_pkg::CAP_W-1:0] csr_write_data
);

   import olog_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   typedef enum logic [0:0] {
      S_IDLE,
      S_LIST
   } state_type;

   // Advance a ring position by n <= DEPTH slots
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] pos,
                                                 input logic [CNT_W-1:0] n);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(pos) + SUM_W'(n);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   state_type        state_ff, state_in;
   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic [IDX_W-1:0] oldest_ff, oldest_in;
   logic [CNT_W-1:0] held_ff, held_in;
   logic [IDX_W-1:0] cursor_ff, cursor_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             last_ff, last_in;

   logic [CNT_W-1:0]      cap_eff;
   logic                  req_fire;
   logic                  issue;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [CNT_W-1:0]      rm_n;
   logic [ENTRY_BITS-1:0] rd_data;

   // Clamp the programmed capacity into 1..DEPTH
   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (capacity_ff > CAP_W'(DEPTH)) begin
         cap_eff = CNT_W'(DEPTH);
      end else begin
         cap_eff = capacity_ff[CNT_W-1:0];
      end
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign issue        = (state_ff == S_LIST) && (!rsp_valid_ff || rsp_ch.ready);

   // Clip the remove count to the held count
   always_comb begin
      if (req_ch.remove_count > COUNT_W'(held_ff)) begin
         rm_n = held_ff;
      end else begin
         rm_n = req_ch.remove_count[CNT_W-1:0];
      end
   end

   // Next-state logic: pointer updates and list sequencing
   always_comb begin
      state_in     = state_ff;
      capacity_in  = csr_write_en ? csr_write_data : capacity_ff;
      oldest_in    = oldest_ff;
      held_in      = held_ff;
      cursor_in    = cursor_ff;
      remain_in    = remain_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_ch.ready ? 1'b0 : rsp_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = ring_add(oldest_ff, held_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_ch.action)
                  ACT_APPEND: begin
                     wr_en = 1'b1;
                     if (held_ff >= cap_eff) begin
                        // drop oldest entries so the new one fits
                        oldest_in = ring_add(oldest_ff, held_ff - cap_eff + CNT_W'(1));
                        held_in   = cap_eff;
                     end else begin
                        held_in = held_ff + CNT_W'(1);
                     end
                  end
                  ACT_REMOVE: begin
                     oldest_in = ring_add(oldest_ff, rm_n);
                     held_in   = held_ff - rm_n;
                  end
                  ACT_LIST: begin
                     if (held_ff != '0) begin
                        cursor_in = oldest_ff;
                        remain_in = held_ff;
                        state_in  = S_LIST;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LIST: begin
            if (issue) begin
               cursor_in    = ring_add(cursor_ff, CNT_W'(1));
               remain_in    = remain_ff - CNT_W'(1);
               last_in      = (remain_ff == CNT_W'(1));
               rsp_valid_in = 1'b1;
               if (remain_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         capacity_ff  <= CAP_RESET;
         oldest_ff    <= '0;
         held_ff      <= '0;
         cursor_ff    <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         capacity_ff  <= capacity_in;
         oldest_ff    <= oldest_in;
         held_ff      <= held_in;
         cursor_ff    <= cursor_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
      end
   end

   // Entry store; its read register drives the response payload
   olog_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ch.entry_value[ENTRY_BITS-1:0]),
      .rd_en   (issue),
      .rd_addr (cursor_ff),
      .rd_data (rd_data)
   );

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.listed_value = VALUE_W'(rd_data);
   assign rsp_ch.last_of_run  = last_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CNT_W'(DEPTH))
      else $error("held count exceeds depth");

   a_oldest_bound: assert property (@(posedge clock) disable iff (reset)
      oldest_ff < IDX_W'(DEPTH - 1) || oldest_ff == IDX_W'(DEPTH - 1))
      else $error("oldest index outside the ring");

   a_full_append: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.action == ACT_APPEND && held_ff >= cap_eff)
      |=> held_ff == $past(cap_eff))
      else $error("append on a full log changed the held count");

   a_list_start: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.action == ACT_LIST && held_ff != '0)
      |=> state_ff == S_LIST && remain_ff == $past(held_ff))
      else $error("list did not start streaming");

   // Reading the newest entry ends the list and flags it
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (issue && remain_ff == CNT_W'(1))
      |=> state_ff == S_IDLE && remain_ff == '0 && rsp_valid_ff && last_ff)
      else $error("last entry read without ending the list");

endmodule

`default_nettype wire
